@@ rtl/sha256_pkg.sv @@
// SHA-256 stream hasher package: constants, types and round functions.
// Used by the datapath, controller and top; depends on nothing.
`default_nettype none
package sha256_pkg;

    localparam int WordW   = 32;
    localparam int CountW  = 61;
    localparam int BufD    = 64;
    localparam int BufAw   = 6;
    localparam int PadPos  = 56;

    localparam logic [7:0] PadByte = 8'h80;

    // Round constants.
    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial chaining values.
    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       init_chain;  // load initial chaining words
        logic       wr_byte;     // write a byte into the block buffer
        logic [1:0] wr_sel;      // byte source select
        logic [5:0] wr_addr;
        logic       start_blk;   // load working vars from chain, clear round counter
        logic       round;       // run one round
        logic       fold;        // add working vars into chain
        logic       shift_out;   // rotate chain words for output
    } t_cmd;

    localparam logic [1:0] SelData = 2'd0;
    localparam logic [1:0] SelPad  = 2'd1;
    localparam logic [1:0] SelZero = 2'd2;
    localparam logic [1:0] SelLen  = 2'd3;

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

endpackage
`default_nettype wire

@@ rtl/sha256_if.sv @@
// Valid/ready stream interfaces for the hasher's input and output.
// Depends on nothing.
`default_nettype none
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    modport source (output valid, data_byte, byte_valid, last, input ready);
    modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

@@ rtl/sha256_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// Depends on nothing.
`default_nettype none
module sha256_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]              o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/sha256_dp.sv @@
// Datapath: block buffer, message schedule window, round unit, chain words.
// Depends on sha256_pkg and sha256_ram.
`default_nettype none
module sha256_dp (
    input  wire logic                i_clk,
    input  wire sha256_pkg::t_cmd    i_cmd,
    input  wire logic [7:0]          i_data,
    input  wire logic [63:0]         i_len_bits,
    input  wire logic [5:0]          i_rd_addr,
    input  wire logic                i_load_w,   // shift a buffer byte into the schedule
    output logic [31:0]              o_head
);
    logic [7:0]  len_byte;
    logic [7:0]  wr_data;
    logic [7:0]  rd_data;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_rnd;
    logic [31:0] w_cur, w_new, s0, s1, t1, t2, e, a;

    // Length byte: address 56 holds the top byte.
    assign len_byte = i_len_bits[8*(7 - i_cmd.wr_addr[2:0]) +: 8];

    always_comb begin
        case (i_cmd.wr_sel)
            sha256_pkg::SelData: wr_data = i_data;
            sha256_pkg::SelPad:  wr_data = sha256_pkg::PadByte;
            sha256_pkg::SelZero: wr_data = 8'd0;
            default:             wr_data = len_byte;
        endcase
    end

    sha256_ram #(.Width(8), .Depth(sha256_pkg::BufD)) u_buf (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_byte),
        .i_waddr(i_cmd.wr_addr),
        .i_wdata(wr_data),
        .i_raddr(i_rd_addr),
        .o_rdata(rd_data)
    );

    // Schedule: rounds 0..15 use loaded words, later ones the recurrence.
    assign s0    = sha256_pkg::ror(r_w[1], 7) ^ sha256_pkg::ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1    = sha256_pkg::ror(r_w[14], 17) ^ sha256_pkg::ror(r_w[14], 19)
                 ^ (r_w[14] >> 10);
    assign w_new = r_w[0] + s0 + r_w[9] + s1;
    assign w_cur = (r_rnd < 6'd16) ? r_w[r_rnd[3:0]] : w_new;

    assign e  = r_v[4];
    assign a  = r_v[0];
    assign t1 = r_v[7] + (sha256_pkg::ror(e, 6) ^ sha256_pkg::ror(e, 11) ^ sha256_pkg::ror(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + sha256_pkg::RoundK[r_rnd] + w_cur;
    assign t2 = (sha256_pkg::ror(a, 2) ^ sha256_pkg::ror(a, 13) ^ sha256_pkg::ror(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Schedule window.
    always_ff @(posedge i_clk) begin
        if (i_load_w) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= {r_w[i][23:0], r_w[i+1][31:24]};
            end
            r_w[15] <= {r_w[15][23:0], rd_data};
        end else if (i_cmd.round && r_rnd >= 6'd16) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
        end
    end

    // Working variables and round counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_blk) begin
            r_v   <= r_h;
            r_rnd <= '0;
        end else if (i_cmd.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= e;
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= a;
            r_v[0] <= t1 + t2;
            r_rnd  <= r_rnd + 6'd1;
        end
    end

    // Chain words.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_chain) begin
            r_h <= sha256_pkg::InitH;
        end else if (i_cmd.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end else if (i_cmd.shift_out) begin
            for (int i = 0; i < 7; i++) begin
                r_h[i] <= r_h[i+1];
            end
            r_h[7] <= r_h[0];
        end
    end

    assign o_head = r_h[0];
endmodule
`default_nettype wire

@@ rtl/sha256_ctrl.sv @@
// Controller: byte intake, padding sweep, block load and round sequencing,
// digest output. Depends on sha256_pkg.
`default_nettype none
module sha256_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_fire,
    input  wire logic              i_byte_valid,
    input  wire logic              i_last,
    input  wire logic              i_out_fire,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output logic [2:0]             o_word_index,
    output sha256_pkg::t_cmd       o_cmd,
    output logic [63:0]            o_len_bits,
    output logic [5:0]             o_rd_addr,
    output logic                   o_load_w
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,  // write 0x80 / zeros / length
        ST_LOAD  = 7'b0000100,  // read 64 bytes into schedule
        ST_RND   = 7'b0001000,
        ST_FOLD  = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_INIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [60:0] r_count, n_count;
    logic [6:0]  r_idx, n_idx;         // sweep / load index
    logic [5:0]  r_rc, n_rc;           // rounds done
    logic        r_final, n_final;     // this block is the last one
    logic        r_padding, n_padding; // within message end
    logic        r_extra, n_extra;     // an extra block follows
    logic [2:0]  r_oi, n_oi;
    logic [5:0]  pos;

    assign pos        = r_count[5:0];
    assign o_len_bits = {r_count, 3'b000};
    assign o_in_ready = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_word_index = r_oi;
    assign o_rd_addr  = r_idx[5:0];
    assign o_load_w   = (r_state == ST_LOAD) && (r_idx != 7'd0);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rc      = r_rc;
        n_final   = r_final;
        n_padding = r_padding;
        n_extra   = r_extra;
        n_oi      = r_oi;
        o_cmd     = '0;
        o_cmd.wr_addr = r_idx[5:0];
        case (r_state)
            ST_IDLE: begin
                o_cmd.wr_addr = pos;
                if (i_in_fire) begin
                    if (i_byte_valid) begin
                        o_cmd.wr_byte = 1'b1;
                        o_cmd.wr_sel  = sha256_pkg::SelData;
                        n_count = r_count + 61'd1;
                    end
                    n_final   = 1'b0;
                    n_padding = i_last;
                    n_idx     = 7'd0;
                    if (i_byte_valid && pos == 6'd63) begin
                        n_state = ST_LOAD;
                    end else if (i_last) begin
                        n_state = ST_PAD;
                        n_idx   = {1'b0, pos} + {6'd0, i_byte_valid};
                        n_extra = ({1'b0, pos} + {6'd0, i_byte_valid}) >= 7'(sha256_pkg::PadPos);
                        n_final = !(({1'b0, pos} + {6'd0, i_byte_valid}) >= 7'(sha256_pkg::PadPos));
                    end
                end
            end
            ST_PAD: begin
                // First entry after the message gets 0x80; the rest zero or length.
                o_cmd.wr_byte = 1'b1;
                if (r_idx[5:0] == r_count[5:0] && !r_extra && !r_final) begin
                    o_cmd.wr_sel = sha256_pkg::SelPad;
                end else if (r_idx[5:0] == r_count[5:0] && r_padding) begin
                    o_cmd.wr_sel = sha256_pkg::SelPad;
                end else if (r_final && r_idx >= 7'(sha256_pkg::PadPos)) begin
                    o_cmd.wr_sel = sha256_pkg::SelLen;
                end else begin
                    o_cmd.wr_sel = sha256_pkg::SelZero;
                end
                n_padding = 1'b0;
                n_idx = r_idx + 7'd1;
                if (r_idx == 7'd63) begin
                    n_state = ST_LOAD;
                    n_idx   = 7'd0;
                end
            end
            ST_LOAD: begin
                n_idx = r_idx + 7'd1;
                if (r_idx == 7'd64) begin
                    n_state = ST_RND;
                    o_cmd.start_blk = 1'b1;
                    n_rc = 6'd0;
                end
            end
            ST_RND: begin
                o_cmd.round = 1'b1;
                n_rc = r_rc + 6'd1;
                if (r_rc == 6'd63) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                n_idx = 7'd0;
                if (r_final) begin
                    n_state = ST_OUT;
                    n_oi    = 3'd0;
                end else if (r_padding) begin
                    // Byte completed a block and the message ends here.
                    n_state = ST_PAD;
                    n_final = 1'b1;
                    n_extra = 1'b0;
                end else if (r_extra) begin
                    n_state = ST_PAD;
                    n_final = 1'b1;
                    n_extra = 1'b0;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (i_out_fire) begin
                    o_cmd.shift_out = 1'b1;
                    n_oi = r_oi + 3'd1;
                    if (r_oi == 3'd7) begin
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.init_chain = 1'b1;
                n_count = '0;
                n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_count   <= '0;
            r_idx     <= '0;
            r_rc      <= '0;
            r_final   <= 1'b0;
            r_padding <= 1'b0;
            r_extra   <= 1'b0;
            r_oi      <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_rc      <= n_rc;
            r_final   <= n_final;
            r_padding <= n_padding;
            r_extra   <= n_extra;
            r_oi      <= n_oi;
        end
    end

    // Input is only taken while idle.
    a_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_fire |-> r_state == ST_IDLE) else $error("input taken while busy");
    // Digest words advance in order.
    a_oi_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && i_out_fire && r_oi != 3'd7) |=> r_oi == $past(r_oi) + 3'd1)
        else $error("word index skipped");
    // Rounds run exactly 64 times before folding.
    a_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FOLD |-> r_rc == 6'd0) else $error("round count wrong at fold");
endmodule
`default_nettype wire

@@ rtl/sha256_stream_hasher_top.sv @@
// SHA-256 stream hasher: one message byte per input request, eight
// digest words per finished message. The controller sequences a
// buffer/round datapath. Depends on sha256_pkg, sha256_if and submodules.
//
// Input channel: data_byte, byte_valid, last. A byte without last that
// does not fill the block is written to the buffer and input stays ready.
// A byte that fills the 64-byte block starts the buffer read-out into the
// schedule, then 64 rounds, one per cycle, then the fold; no input is
// taken meanwhile.
// An item with last sweeps the rest of the buffer for padding, compresses
// once or twice, then presents eight digest words, word 0 first,
// last_word on word 7.
// Output words are held while the receiver stalls; no new input is taken
// until the eighth word is taken and ST_INIT has returned the chain to
// its initial values. Reset also enters ST_INIT to load them.
`default_nettype none
module sha256_stream_hasher_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sha256_in_if.sink    i_in,
    sha256_out_if.source o_out
);
    sha256_pkg::t_cmd cmd;
    logic [63:0] len_bits;
    logic [5:0]  rd_addr;
    logic        load_w;
    logic [31:0] head;
    logic        in_fire, out_fire;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;

    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_byte_valid(i_in.byte_valid),
        .i_last      (i_in.last),
        .i_out_fire  (out_fire),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_word_index(o_out.word_index),
        .o_cmd       (cmd),
        .o_len_bits  (len_bits),
        .o_rd_addr   (rd_addr),
        .o_load_w    (load_w)
    );

    sha256_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (cmd),
        .i_data    (i_in.data_byte),
        .i_len_bits(len_bits),
        .i_rd_addr (rd_addr),
        .i_load_w  (load_w),
        .o_head    (head)
    );

    assign o_out.digest_word = head;
    assign o_out.last_word   = (o_out.word_index == 3'd7);
endmodule
`default_nettype wire
